>>> hw/rtl/cfa_pkg.sv
package cfa_pkg;
   localparam int MaxAllocs = 32;
   localparam int MaxHoles = 33;
   localparam int AddrBits = 16;
   localparam int IdBits = $clog2(MaxAllocs);
   localparam int HoleIdxBits = $clog2(MaxHoles);
   localparam int HoleCntBits = $clog2(MaxHoles + 1);
   localparam int LenBits = AddrBits + 1;
   localparam int HoleWidth = 2 * LenBits;
   localparam int AllocWidth = AddrBits + LenBits;

   localparam logic [1:0] MODE_FIRST = 2'd0;
   localparam logic [1:0] MODE_BEST = 2'd1;
   localparam logic [1:0] MODE_WORST = 2'd2;
   localparam logic [1:0] MODE_FREE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOHOLE = 2'd1;
   localparam logic [1:0] ST_NOSLOT = 2'd2;
   localparam logic [1:0] ST_NOTLIVE = 2'd3;

   localparam logic [LenBits-1:0] FullSize = LenBits'(1) << AddrBits;
endpackage

>>> hw/rtl/cfa_ram.sv
module cfa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/contiguous_fit_allocator.sv
// Contiguous-fit allocator with a request channel (req_), a response
// channel (rsp_) and a write channel for the managed size (csr_).
// A request either allocates req_size words (first, best or worst fit by
// req_mode) or frees allocation req_alloc_id. Each request gives exactly
// one response with status, id and start address.
// Holes live in a synchronous RAM sorted by address; allocations in a
// second RAM indexed by id, with valid bits in flip-flops.
// One request at a time: a scan reads the hole RAM one entry at a time
// (S_SCAN, S_SCANW), then holes are shifted one entry at a time (S_SHIFT,
// S_SHIFTW) to insert or remove one. A rejected free or a zero size
// answers in the cycle after the transfer. Holes shift only when an
// allocation uses up the chosen hole or a free merges two holes or adds one.
// The next request is taken in the cycle after the response transfer.
// Reset, and a size write, leave one hole spanning the memory and no live
// allocation after one cycle of initialization; csr_ready is high only
// while the block is idle, and req_stall is high while a write is offered.
// A stalled response holds in its output register and the block takes no
// new request until that transfer completes.
module contiguous_fit_allocator
   import cfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [LenBits-1:0]  req_size,
   input  logic [IdBits-1:0]   req_alloc_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [IdBits-1:0]   rsp_result_id,
   output logic [AddrBits-1:0] rsp_base_addr,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LenBits-1:0]  csr_mem_words
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_SCANW = 4'd2;
   localparam logic [3:0] S_AREAD = 4'd3;
   localparam logic [3:0] S_AWAIT = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_SHIFT = 4'd6;
   localparam logic [3:0] S_SHIFTW = 4'd7;
   localparam logic [3:0] S_FIN = 4'd8;
   localparam logic [3:0] S_OUT = 4'd9;
   localparam logic [3:0] S_INIT = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic [LenBits-1:0] size_ff, size_in;
   logic [IdBits-1:0] id_ff, id_in;
   logic [LenBits-1:0] msize_ff, msize_in;
   logic [HoleCntBits-1:0] hcnt_ff, hcnt_in;
   logic [HoleCntBits-1:0] ptr_ff, ptr_in;
   logic found_ff, found_in;
   logic [HoleIdxBits-1:0] pick_ff, pick_in;
   logic [LenBits-1:0] best_ff, best_in;
   logic [LenBits-1:0] pstart_ff, pstart_in, pend_ff, pend_in;
   logic [LenBits-1:0] fs_ff, fs_in, fe_ff, fe_in;
   logic [LenBits-1:0] prev_start_ff, prev_start_in;
   logic [LenBits-1:0] prev_end_ff, prev_end_in;
   logic [LenBits-1:0] shs_ff, shs_in, she_ff, she_in;
   logic shdir_ff, shdir_in;
   logic [MaxAllocs-1:0] avalid_ff, avalid_in;
   logic [1:0] st_ff, st_in;
   logic [IdBits-1:0] rid_ff, rid_in;
   logic [AddrBits-1:0] radr_ff, radr_in;

   logic h_we;
   logic [HoleIdxBits-1:0] h_wa, h_ra;
   logic [HoleWidth-1:0] h_wd, h_rd;
   logic a_we;
   logic [IdBits-1:0] a_wa, a_ra;
   logic [AllocWidth-1:0] a_wd, a_rd;

   cfa_ram #(.Width(HoleWidth), .Depth(MaxHoles)) u_holes (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd)
   );
   cfa_ram #(.Width(AllocWidth), .Depth(MaxAllocs)) u_allocs (
      .clock(clock), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
      .rd_addr(a_ra), .rd_data(a_rd)
   );

   logic [LenBits-1:0] rd_s, rd_e, rd_len, csr_clamp;
   logic [IdBits-1:0] free_id;
   logic have_free;

   assign rd_s = h_rd[HoleWidth-1:LenBits];
   assign rd_e = h_rd[LenBits-1:0];
   assign rd_len = rd_e - rd_s;
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_status = st_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_base_addr = radr_ff;

   always_comb begin
      csr_clamp = csr_mem_words;
      if (csr_mem_words == '0) begin
         csr_clamp = LenBits'(1);
      end else if (csr_mem_words > FullSize) begin
         csr_clamp = FullSize;
      end
   end

   always_comb begin
      free_id = '0;
      have_free = 1'b0;
      for (int i = MaxAllocs - 1; i >= 0; i--) begin
         if (!avalid_ff[i]) begin
            free_id = IdBits'(i);
            have_free = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      size_in = size_ff;
      id_in = id_ff;
      msize_in = msize_ff;
      hcnt_in = hcnt_ff;
      ptr_in = ptr_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      best_in = best_ff;
      pstart_in = pstart_ff;
      pend_in = pend_ff;
      fs_in = fs_ff;
      fe_in = fe_ff;
      prev_start_in = prev_start_ff;
      prev_end_in = prev_end_ff;
      shs_in = shs_ff;
      she_in = she_ff;
      shdir_in = shdir_ff;
      avalid_in = avalid_ff;
      st_in = st_ff;
      rid_in = rid_ff;
      radr_in = radr_ff;
      h_we = 1'b0;
      h_wa = '0;
      h_wd = '0;
      h_ra = ptr_ff[HoleIdxBits-1:0];
      a_we = 1'b0;
      a_wa = '0;
      a_wd = '0;
      a_ra = id_ff;
      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               msize_in = csr_clamp;
               state_in = S_INIT;
            end else if (req_valid) begin
               mode_in = req_mode;
               size_in = req_size;
               id_in = req_alloc_id;
               ptr_in = '0;
               found_in = 1'b0;
               best_in = '0;
               pick_in = '0;
               if (req_mode == MODE_FREE) begin
                  if (!avalid_ff[req_alloc_id]) begin
                     st_in = ST_NOTLIVE;
                     rid_in = req_alloc_id;
                     radr_in = '0;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_AREAD;
                  end
               end else if (req_size == '0) begin
                  st_in = ST_NOHOLE;
                  rid_in = '0;
                  radr_in = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_INIT: begin
            h_we = 1'b1;
            h_wa = '0;
            h_wd = {LenBits'(0), msize_ff};
            hcnt_in = HoleCntBits'(1);
            avalid_in = '0;
            state_in = S_IDLE;
         end
         S_AREAD: begin
            state_in = S_AWAIT;
         end
         S_AWAIT: begin
            fs_in = {1'b0, a_rd[AllocWidth-1:LenBits]};
            fe_in = a_rd[LenBits-1:0];
            prev_end_in = {LenBits{1'b1}};
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (ptr_ff >= hcnt_ff) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SCANW;
            end
         end
         S_SCANW: begin
            if (mode_ff == MODE_FREE) begin
               if (rd_s < fe_ff) begin
                  prev_start_in = rd_s;
                  prev_end_in = rd_e;
                  ptr_in = ptr_ff + 1'b1;
                  state_in = S_SCAN;
               end else begin
                  found_in = 1'b1;
                  pstart_in = rd_s;
                  pend_in = rd_e;
                  state_in = S_DECIDE;
               end
            end else begin
               if (rd_len >= size_ff && (!found_ff ||
                     (mode_ff == MODE_BEST && rd_len < best_ff) ||
                     (mode_ff == MODE_WORST && rd_len > best_ff))) begin
                  found_in = 1'b1;
                  pick_in = ptr_ff[HoleIdxBits-1:0];
                  best_in = rd_len;
                  pstart_in = rd_s;
                  pend_in = rd_e;
               end
               if (mode_ff == MODE_FIRST && rd_len >= size_ff) begin
                  state_in = S_DECIDE;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_DECIDE: begin
            state_in = S_OUT;
            if (mode_ff == MODE_FREE) begin
               // ptr is p; found says p < hole_count with pstart/pend its entry.
               rid_in = id_ff;
               radr_in = '0;
               st_in = ST_OK;
               if (ptr_ff != '0 && prev_end_ff == fs_ff
                     && found_ff && pstart_ff == fe_ff) begin
                  h_we = 1'b1;
                  h_wa = HoleIdxBits'(ptr_ff - 1'b1);
                  h_wd = {prev_start_ff, pend_ff};
                  shdir_in = 1'b0;
                  state_in = S_SHIFT;
               end else if (ptr_ff != '0 && prev_end_ff == fs_ff) begin
                  h_we = 1'b1;
                  h_wa = HoleIdxBits'(ptr_ff - 1'b1);
                  h_wd = {prev_start_ff, fe_ff};
                  state_in = S_FIN;
               end else if (found_ff && pstart_ff == fe_ff) begin
                  h_we = 1'b1;
                  h_wa = ptr_ff[HoleIdxBits-1:0];
                  h_wd = {fs_ff, pend_ff};
                  state_in = S_FIN;
               end else if (hcnt_ff >= HoleCntBits'(MaxHoles)) begin
                  st_in = ST_NOSLOT;
               end else begin
                  shdir_in = 1'b1;
                  shs_in = fs_ff;
                  she_in = fe_ff;
                  state_in = S_SHIFT;
               end
            end else if (!found_ff) begin
               st_in = ST_NOHOLE;
               rid_in = '0;
               radr_in = '0;
            end else if (!have_free) begin
               st_in = ST_NOSLOT;
               rid_in = '0;
               radr_in = '0;
            end else begin
               st_in = ST_OK;
               rid_in = free_id;
               radr_in = pstart_ff[AddrBits-1:0];
               avalid_in[free_id] = 1'b1;
               a_we = 1'b1;
               a_wa = free_id;
               a_wd = {pstart_ff[AddrBits-1:0], pstart_ff + size_ff};
               h_we = 1'b1;
               h_wa = pick_ff;
               h_wd = {pstart_ff + size_ff, pend_ff};
               if (pstart_ff + size_ff == pend_ff) begin
                  ptr_in = HoleCntBits'(pick_ff);
                  shdir_in = 1'b0;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (shdir_ff) begin
               if (ptr_ff >= hcnt_ff) begin
                  h_we = 1'b1;
                  h_wa = ptr_ff[HoleIdxBits-1:0];
                  h_wd = {shs_ff, she_ff};
                  hcnt_in = hcnt_ff + 1'b1;
                  state_in = S_FIN;
               end else begin
                  state_in = S_SHIFTW;
               end
            end else begin
               if (ptr_ff + 1'b1 >= hcnt_ff) begin
                  hcnt_in = hcnt_ff - 1'b1;
                  state_in = (mode_ff == MODE_FREE) ? S_FIN : S_OUT;
               end else begin
                  h_ra = HoleIdxBits'(ptr_ff + 1'b1);
                  state_in = S_SHIFTW;
               end
            end
         end
         S_SHIFTW: begin
            h_we = 1'b1;
            h_wa = ptr_ff[HoleIdxBits-1:0];
            if (shdir_ff) begin
               h_wd = {shs_ff, she_ff};
               shs_in = rd_s;
               she_in = rd_e;
            end else begin
               h_wd = h_rd;
            end
            ptr_in = ptr_ff + 1'b1;
            state_in = S_SHIFT;
         end
         S_FIN: begin
            if (mode_ff == MODE_FREE && st_ff == ST_OK) begin
               avalid_in[id_ff] = 1'b0;
               radr_in = fs_ff[AddrBits-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         msize_ff <= FullSize;
         hcnt_ff <= HoleCntBits'(1);
         avalid_ff <= '0;
      end else begin
         state_ff <= state_in;
         msize_ff <= msize_in;
         hcnt_ff <= hcnt_in;
         avalid_ff <= avalid_in;
      end
      mode_ff <= mode_in;
      size_ff <= size_in;
      id_ff <= id_in;
      ptr_ff <= ptr_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
      pstart_ff <= pstart_in;
      pend_ff <= pend_in;
      fs_ff <= fs_in;
      fe_ff <= fe_in;
      prev_start_ff <= prev_start_in;
      prev_end_ff <= prev_end_in;
      shdir_ff <= shdir_in;
      st_ff <= st_in;
      rid_ff <= rid_in;
      radr_ff <= radr_in;
      shs_ff <= shs_in;
      she_ff <= she_in;
   end
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cfa_pkg::*;

   typedef struct packed {
      logic [1:0]         mode;
      logic [LenBits-1:0] size;
      logic [IdBits-1:0]  alloc_id;
   } request_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [IdBits-1:0]   result_id;
      logic [AddrBits-1:0] base_addr;
   } response_type;

   localparam int StallLimit = 2000;
   localparam int SettleCycles = 3 * MaxHoles + 20;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_mode;
   logic [LenBits-1:0]  req_size;
   logic [IdBits-1:0]   req_alloc_id;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [1:0]          rsp_status;
   logic [IdBits-1:0]   rsp_result_id;
   logic [AddrBits-1:0] rsp_base_addr;
   logic                csr_valid;
   logic                csr_ready;
   logic [LenBits-1:0]  csr_mem_words;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int        mismatch_count = 0;
   int        quiet_cycles = 0;
   bit        no_idle = 0;
   int        send_gap = 0;
   int        hold_left = 0;

   logic [LenBits-1:0] mem_words;
   logic [LenBits-1:0] hole_lo[MaxHoles];
   logic [LenBits-1:0] hole_hi[MaxHoles];
   int                 hole_num;
   bit                 live[MaxAllocs];
   logic [LenBits-1:0] region_lo[MaxAllocs];
   logic [LenBits-1:0] region_hi[MaxAllocs];

   contiguous_fit_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_size         (req_size),
      .req_alloc_id     (req_alloc_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_id    (rsp_result_id),
      .rsp_base_addr    (rsp_base_addr),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_mem_words    (csr_mem_words)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic void clear_layout(input logic [LenBits-1:0] words);
      mem_words = words;
      hole_num = 1;
      hole_lo[0] = '0;
      hole_hi[0] = words;
      for (int i = 0; i < MaxAllocs; i++) begin
         live[i] = 1'b0;
      end
   endfunction

   function automatic void drop_hole(input int p);
      for (int i = p; i + 1 < hole_num; i++) begin
         hole_lo[i] = hole_lo[i + 1];
         hole_hi[i] = hole_hi[i + 1];
      end
      hole_num--;
   endfunction

   function automatic response_type allocate_region(input logic [1:0] mode,
                                                    input logic [LenBits-1:0] size);
      response_type r;
      logic [LenBits-1:0] len;
      logic [LenBits-1:0] best_len;
      logic [LenBits-1:0] s;
      int pick;
      int id;
      bit found;
      r = '0;
      found = 0;
      pick = 0;
      best_len = '0;
      if (size != 0) begin
         for (int i = 0; i < hole_num; i++) begin
            len = hole_hi[i] - hole_lo[i];
            if (len >= size && (!found || (mode == MODE_BEST && len < best_len) ||
                                (mode == MODE_WORST && len > best_len))) begin
               pick = i;
               best_len = len;
               found = 1;
               if (mode == MODE_FIRST) break;
            end
         end
      end
      if (!found) begin
         r.status = ST_NOHOLE;
         return r;
      end
      id = 0;
      while (id < MaxAllocs && live[id]) id++;
      if (id >= MaxAllocs) begin
         r.status = ST_NOSLOT;
         return r;
      end
      s = hole_lo[pick];
      live[id] = 1'b1;
      region_lo[id] = s;
      region_hi[id] = s + size;
      hole_lo[pick] = s + size;
      if (hole_lo[pick] == hole_hi[pick]) drop_hole(pick);
      r.status = ST_OK;
      r.result_id = id[IdBits-1:0];
      r.base_addr = s[AddrBits-1:0];
      return r;
   endfunction

   function automatic response_type release_region(input logic [IdBits-1:0] id);
      response_type r;
      logic [LenBits-1:0] s;
      logic [LenBits-1:0] e;
      int p;
      bit left;
      bit right;
      r = '0;
      r.result_id = id;
      if (!live[id]) begin
         r.status = ST_NOTLIVE;
         return r;
      end
      s = region_lo[id];
      e = region_hi[id];
      p = 0;
      while (p < hole_num && hole_lo[p] < e) p++;
      left = (p > 0) && (hole_hi[p - 1] == s);
      right = (p < hole_num) && (hole_lo[p] == e);
      if (left && right) begin
         hole_hi[p - 1] = hole_hi[p];
         drop_hole(p);
      end else if (left) begin
         hole_hi[p - 1] = e;
      end else if (right) begin
         hole_lo[p] = s;
      end else begin
         if (hole_num >= MaxHoles) begin
            r.status = ST_NOSLOT;
            return r;
         end
         for (int i = hole_num; i > p; i--) begin
            hole_lo[i] = hole_lo[i - 1];
            hole_hi[i] = hole_hi[i - 1];
         end
         hole_lo[p] = s;
         hole_hi[p] = e;
         hole_num++;
      end
      live[id] = 1'b0;
      r.status = ST_OK;
      r.base_addr = s[AddrBits-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      request_type item;
      bit busy;
      if (reset) begin
         req_valid <= 1'b0;
         req_mode <= '0;
         req_size <= '0;
         req_alloc_id <= '0;
         send_gap = 0;
      end else begin
         busy = req_valid;
         if (req_valid && !req_stall) begin
            if (req_mode == MODE_FREE) begin
               expected_responses.insert(expected_responses.size(),
                                         release_region(req_alloc_id));
            end else begin
               expected_responses.insert(expected_responses.size(),
                                         allocate_region(req_mode, req_size));
            end
            busy = 0;
            send_gap = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               item = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_mode <= item.mode;
               req_size <= item.size;
               req_alloc_id <= item.alloc_id;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected transfer: status %0d id %0d address %0d",
                           rsp_status, rsp_result_id, rsp_base_addr);
               end
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status || rsp_result_id !== want.result_id ||
                   rsp_base_addr !== want.base_addr) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected status %0d id %0d address %0d, got %0d %0d %0d",
                              want.status, want.result_id, want.base_addr,
                              rsp_status, rsp_result_id, rsp_base_addr);
                  end
               end
            end
            hold_left = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("contiguous_fit_allocator test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(input logic [1:0] mode, input logic [LenBits-1:0] size,
                                input logic [IdBits-1:0] id);
      request_type item;
      item.mode = mode;
      item.size = size;
      item.alloc_id = id;
      pending_requests.insert(pending_requests.size(), item);
   endtask

   task automatic drain;
      do @(posedge clock);
      while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_mem_words(input logic [LenBits-1:0] value);
      logic [LenBits-1:0] words;
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_mem_words <= value;
      do @(posedge clock);
      while (!csr_ready);
      words = value;
      if (words == 0) words = 1;
      if (words > FullSize) words = FullSize;
      clear_layout(words);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(input int count);
      int roll;
      int cap;
      logic [LenBits-1:0] size;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         cap = (mem_words / 24 > 1) ? mem_words / 24 : 1;
         if (roll < 80) size = LenBits'($urandom_range(1, cap));
         else if (roll < 94) size = LenBits'($urandom_range(1, mem_words + 2));
         else if (roll < 97) size = LenBits'($urandom);
         else size = '0;
         if ($urandom_range(0, 99) < 35) begin
            queue_request(MODE_FREE, LenBits'($urandom), IdBits'($urandom));
         end else begin
            queue_request(2'($urandom_range(MODE_FIRST, MODE_WORST)), size,
                          IdBits'($urandom));
         end
      end
   endtask

   initial begin
      logic [LenBits-1:0] settings[10];
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_mem_words = '0;
      clear_layout(FullSize);
      settings = '{17'd1, 17'h1FFFF, 17'd0, 17'd100, 17'd65535,
                   17'd65537, 17'd2, 17'd1000, 17'd40, 17'd65536};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      queue_request(MODE_FIRST, 17'd100, 5'd31);
      queue_request(MODE_FIRST, 17'd200, 5'd0);
      queue_request(MODE_FIRST, 17'd300, 5'd7);
      queue_request(MODE_FREE, 17'h1FFFF, 5'd1);
      queue_request(MODE_BEST, 17'd50, 5'd0);
      queue_request(MODE_WORST, 17'd10, 5'd0);
      queue_request(MODE_FIRST, 17'd0, 5'd0);
      queue_request(MODE_BEST, 17'h1FFFF, 5'd0);
      queue_request(MODE_WORST, FullSize, 5'd0);
      queue_request(MODE_FREE, 17'd0, 5'd31);
      queue_request(MODE_FREE, 17'd0, 5'd1);
      queue_request(MODE_FREE, 17'd0, 5'd0);
      queue_request(MODE_FREE, 17'd0, 5'd3);
      queue_request(MODE_FREE, 17'd0, 5'd2);
      queue_request(MODE_FREE, 17'd0, 5'd1);
      queue_request(MODE_BEST, FullSize, 5'd0);
      queue_request(MODE_FIRST, 17'd1, 5'd0);
      queue_request(MODE_FREE, 17'd0, 5'd0);
      queue_request(MODE_WORST, 17'd65535, 5'd0);
      queue_request(MODE_FIRST, 17'd1, 5'd0);
      queue_request(MODE_FREE, 17'd0, 5'd0);
      queue_request(MODE_FREE, 17'd0, 5'd1);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         no_idle = (ph % 4 == 2);
         write_mem_words(settings[ph]);
         queue_random(128);
         drain();
      end

      if (mismatch_count == 0) begin
         $display("contiguous_fit_allocator test passed");
      end else begin
         $display("contiguous_fit_allocator test failed");
      end
      $finish;
   end
endmodule

>>> contiguous_fit_allocator.f
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_ram.sv
hw/rtl/contiguous_fit_allocator.sv
tb/sv/testbench.sv
